/* rtl/prc_pkg.sv */
// ----------------------------------------------------------------------------
// prc_pkg: shared definitions for the polar/rectangular converter
// Holds the number formats, the action codes, the arctangent table, the CORDIC
// gain correction and the structures that travel down the pipeline.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Build-time configuration.
  localparam int CORDIC_STAGES = 16;   // 8 .. 30
  localparam int FRACTION_BITS = 16;   // 8 .. 24

  // Port formats.
  localparam int DATA_W = 32;
  localparam int ACT_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD     = 2'd0,
    ACT_TO_RECT  = 2'd1,
    ACT_TO_POLAR = 2'd2,
    ACT_INVALID  = 2'd3
  } action_t;

  // Internal formats: angles in degrees with 24 fraction bits, vectors with
  // four guard bits and two bits of headroom for the CORDIC growth.
  localparam int ANG_FRAC  = 24;
  localparam int ANG_W     = 34;
  localparam int GUARD     = 4;
  localparam int VEC_W     = DATA_W + GUARD + 2;
  localparam int ANG_SHIFT = ANG_FRAC - FRACTION_BITS;

  localparam logic signed [ANG_W-1:0] FULL    = ANG_W'(64'd360 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] HALF    = ANG_W'(64'd180 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(64'd90 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] NHALF    = -HALF;
  localparam logic signed [ANG_W-1:0] NQUARTER = -QUARTER;

  // Angle reduction modulo 360 degrees on the integer part of the angle.
  localparam int IP_W    = DATA_W - FRACTION_BITS;
  localparam int RED_SH  = IP_W + 9;
  localparam int RECIP_W = IP_W + 2;
  localparam int PR_W    = IP_W + RECIP_W;
  localparam int RED_W   = IP_W + 10;
  localparam int DEG_W   = 9;
  localparam longint RECIP_L = (longint'(1) << RED_SH) / 360 + 1;
  localparam logic signed [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic [DEG_W-1:0] DEG_FULL = DEG_W'(360);

  // Gain correction multiply.
  localparam int INV_FRAC = 26;
  localparam int INV_W    = INV_FRAC + 1;
  localparam int LO_W     = VEC_W / 2;
  localparam int HI_W     = VEC_W - LO_W;
  localparam int PH_W     = HI_W + INV_W;
  localparam int PL_W     = LO_W + 1 + INV_W;
  localparam int SUM_W    = VEC_W + INV_W + 1;
  localparam int OUT_SH   = INV_FRAC + GUARD;
  localparam int SCL_W    = SUM_W - OUT_SH;

  // Arctangent of 2^-i in degrees, 24 fraction bits.
  function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
    logic [63:0] v;
    v = 64'd0;
    case (i)
      0:       v = 64'd754974720;
      1:       v = 64'd445687602;
      2:       v = 64'd235489089;
      3:       v = 64'd119537938;
      4:       v = 64'd60000934;
      5:       v = 64'd30029717;
      6:       v = 64'd15018523;
      7:       v = 64'd7509720;
      8:       v = 64'd3754917;
      9:       v = 64'd1877466;
      10:      v = 64'd938734;
      11:      v = 64'd469367;
      12:      v = 64'd234684;
      13:      v = 64'd117342;
      14:      v = 64'd58671;
      15:      v = 64'd29335;
      default: v = (64'd961263669 + (64'd1 << (i - 1))) >> i;
    endcase
    return ANG_W'(v);
  endfunction

  // Inverse CORDIC gain in Q.26, evaluated at elaboration. The square of the
  // gain is accumulated in Q4.60, its square root taken bit by bit and the
  // reciprocal formed by restoring division.
  function automatic logic [63:0] inv_gain_calc();
    logic [63:0] g;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] k;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    g = 64'd1 << 60;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      g = g + (g >> (2 * i));
    end
    v = g;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) begin
      b = b >> 2;
    end
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    k = (r == 64'd0) ? 64'd1 : r;
    num = (64'd1 << 56) + (k >> 1);
    q = 64'd0;
    rem = 64'd0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[62:0], num[j]};
      if (rem >= k) begin
        rem = rem - k;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam logic signed [INV_W-1:0] INV_GAIN = INV_W'(inv_gain_calc());

  // One CORDIC working point.
  typedef struct packed {
    logic                    vec;   // vectoring (drive y to zero)
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

  // Side information that rides along with each transaction.
  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic                     zero_vec;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } side_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] first_out;
    logic signed [DATA_W-1:0] second_out;
    logic                     error_flag;
  } result_t;

endpackage

/* rtl/prc_operand_if.sv */
// ----------------------------------------------------------------------------
// prc_operand_if: operand channel of the converter
// Carries the action code and the two Q-format operands with valid/ready.
// ----------------------------------------------------------------------------
interface prc_operand_if import prc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] first_in;
  logic signed [DATA_W-1:0] second_in;

  modport source (output valid, action, first_in, second_in, input ready);
  modport sink (input valid, action, first_in, second_in, output ready);
endinterface

/* rtl/prc_result_if.sv */
// ----------------------------------------------------------------------------
// prc_result_if: result channel of the converter
// Carries the two result operands and the error flag with valid/ready.
// ----------------------------------------------------------------------------
interface prc_result_if import prc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] first_out;
  logic signed [DATA_W-1:0] second_out;
  logic                     error_flag;

  modport source (output valid, first_out, second_out, error_flag, input ready);
  modport sink (input valid, first_out, second_out, error_flag, output ready);
endinterface

/* rtl/polar_rect_converter.sv */
// ----------------------------------------------------------------------------
// polar_rect_converter: polar/rectangular conversion by pipelined CORDIC
// Pass-through, polar to rectangular, rectangular to polar (angles in
// degrees) and an invalid code that returns zeros with the error flag.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake     Payload
//   operand   in          valid/ready   action, first_in, second_in
//   result    out         valid/ready   first_out, second_out, error_flag
//
// One transaction enters per clock while the output skid entry is empty. The
// pipeline has three stages of angle reduction and setup, one stage per CORDIC
// micro-rotation, and three stages for the gain multiply, rounding and saturation.
// Reset clears all valid bits, including that of the output skid entry.
// The whole pipeline advances while the one-entry skid register at the output
// is empty; operand.ready is low only while it holds a transaction.
// ----------------------------------------------------------------------------
module polar_rect_converter import prc_pkg::*; (
  input logic           clk,
  input logic           rst,
  prc_operand_if.sink   operand,
  prc_result_if.source  result
);

  localparam int                        PAD_Z   = ANG_W - DEG_W - FRACTION_BITS;
  localparam logic signed [RED_W-1:0]   DEG_R   = RED_W'(360);
  localparam logic signed [ANG_W:0]     ANG_RND =
    (ANG_SHIFT > 0) ? ((ANG_W+1)'(1) << (ANG_SHIFT - 1)) : '0;
  localparam logic signed [SUM_W-1:0]   OUT_RND = SUM_W'(1) << (OUT_SH - 1);
  localparam logic signed [SCL_W-1:0]   SAT_HI  = SCL_W'(32'h7fffffff);
  localparam logic signed [SCL_W-1:0]   SAT_LO  = ~SAT_HI;

  // Clamp to the 32-bit signed range; the top bit reports saturation.
  function automatic logic [DATA_W:0] saturate(input logic signed [SCL_W-1:0] v);
    logic [DATA_W:0] r;
    if (v > SAT_HI) begin
      r = {1'b1, SAT_HI[DATA_W-1:0]};
    end else if (v < SAT_LO) begin
      r = {1'b1, SAT_LO[DATA_W-1:0]};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  logic advance;
  logic skid_valid;

  // Stage 1: integer degrees times the reciprocal of 360.
  logic                         s1_valid;
  side_t                        s1_side;
  logic signed [IP_W-1:0]       s1_ip;
  logic [FRACTION_BITS-1:0]     s1_frac;
  logic signed [PR_W-1:0]       s1_prod;
  logic signed [IP_W-1:0]       ang_int;
  side_t                        side_in;

  // Stage 2: angle reduced modulo 360 degrees.
  logic                         s2_valid;
  side_t                        s2_side;
  logic [DEG_W-1:0]             s2_deg;
  logic [FRACTION_BITS-1:0]     s2_frac;
  logic signed [PR_W-1:0]       q_full;
  logic signed [IP_W-1:0]       quo;
  logic signed [RED_W-1:0]      q_ext;
  logic signed [RED_W-1:0]      q_mul;
  logic signed [RED_W-1:0]      ip_ext;
  logic signed [RED_W-1:0]      r_raw;
  logic [DEG_W-1:0]             deg_next;

  // Stage 3: CORDIC start point.
  logic                         s3_valid;
  cordic_t                      s3_data;
  side_t                        s3_side;
  cordic_t                      s3_next;
  logic signed [VEC_W-1:0]      a_ext;
  logic signed [VEC_W-1:0]      b_ext;
  logic signed [ANG_W-1:0]      z_red;
  logic signed [ANG_W-1:0]      z_wrap;

  // CORDIC output.
  logic                         c_valid;
  cordic_t                      c_data;
  side_t                        c_side;

  // Post stages.
  logic                         q1_valid;
  side_t                        q1_side;
  logic [DATA_W-1:0]            q1_ang;
  logic signed [PH_W-1:0]       q1_pxh;
  logic signed [PL_W-1:0]       q1_pxl;
  logic signed [PH_W-1:0]       q1_pyh;
  logic signed [PL_W-1:0]       q1_pyl;
  logic signed [ANG_W-1:0]      z_clamp;
  logic signed [ANG_W:0]        ang_sum;
  logic signed [ANG_W:0]        ang_sh;
  logic signed [HI_W-1:0]       x_hi;
  logic signed [LO_W:0]         x_lo;
  logic signed [HI_W-1:0]       y_hi;
  logic signed [LO_W:0]         y_lo;

  logic                         q2_valid;
  side_t                        q2_side;
  logic [DATA_W-1:0]            q2_ang;
  logic signed [SUM_W-1:0]      q2_sx;
  logic signed [SUM_W-1:0]      q2_sy;
  logic signed [SUM_W-1:0]      sx_next;
  logic signed [SUM_W-1:0]      sy_next;

  logic                         res_valid;
  result_t                      res_q;
  logic [ACT_W-1:0]             res_action;
  result_t                      res_next;
  logic signed [SUM_W-1:0]      sx_sh;
  logic signed [SUM_W-1:0]      sy_sh;
  logic [DATA_W:0]              sat_x;
  logic [DATA_W:0]              sat_y;

  result_t                      skid_res;
  result_t                      out_res;

  assign advance       = !skid_valid;
  assign operand.ready = !skid_valid;

  // Stage 1 inputs.
  always_comb begin
    ang_int          = operand.second_in[DATA_W-1:FRACTION_BITS];
    side_in.action   = operand.action;
    side_in.zero_vec = (operand.first_in == '0) && (operand.second_in == '0);
    side_in.a        = operand.first_in;
    side_in.b        = operand.second_in;
  end

  // Stage 2: quotient estimate, remainder and one correction step each way.
  always_comb begin
    q_full = s1_prod >>> RED_SH;
    quo    = q_full[IP_W-1:0];
    q_ext  = {{(RED_W-IP_W){quo[IP_W-1]}}, quo};
    ip_ext = {{(RED_W-IP_W){s1_ip[IP_W-1]}}, s1_ip};
    q_mul  = q_ext * DEG_R;
    r_raw  = ip_ext - q_mul;
    if (r_raw[RED_W-1]) begin
      deg_next = DEG_W'(r_raw + DEG_R);
    end else if (r_raw >= DEG_R) begin
      deg_next = DEG_W'(r_raw - DEG_R);
    end else begin
      deg_next = DEG_W'(r_raw);
    end
  end

  // Stage 3: wrap and fold the angle, or prepare the vector for vectoring.
  always_comb begin
    a_ext  = {{(VEC_W-DATA_W-GUARD){s2_side.a[DATA_W-1]}}, s2_side.a, {GUARD{1'b0}}};
    b_ext  = {{(VEC_W-DATA_W-GUARD){s2_side.b[DATA_W-1]}}, s2_side.b, {GUARD{1'b0}}};
    z_red  = {{PAD_Z{1'b0}}, s2_deg, s2_frac} << ANG_SHIFT;
    z_wrap = (z_red > HALF) ? (z_red - FULL) : z_red;
    s3_next.vec = (s2_side.action == ACT_TO_POLAR);
    if (s3_next.vec) begin
      if (s2_side.a[DATA_W-1]) begin
        s3_next.x = -a_ext;
        s3_next.y = -b_ext;
        s3_next.z = s2_side.b[DATA_W-1] ? NHALF : HALF;
      end else begin
        s3_next.x = a_ext;
        s3_next.y = b_ext;
        s3_next.z = '0;
      end
    end else begin
      s3_next.y = '0;
      if (z_wrap > QUARTER) begin
        s3_next.x = -a_ext;
        s3_next.z = z_wrap - HALF;
      end else if (z_wrap < NQUARTER) begin
        s3_next.x = -a_ext;
        s3_next.z = z_wrap + HALF;
      end else begin
        s3_next.x = a_ext;
        s3_next.z = z_wrap;
      end
    end
  end

  // Front-end valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= operand.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Front-end payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_side <= side_in;
      s1_ip   <= ang_int;
      s1_frac <= operand.second_in[FRACTION_BITS-1:0];
      s1_prod <= ang_int * RECIP;
      s2_side <= s1_side;
      s2_deg  <= deg_next;
      s2_frac <= s1_frac;
      s3_side <= s2_side;
      s3_data <= s3_next;
    end
  end

  prc_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s3_valid),
    .in_data   (s3_data),
    .in_side   (s3_side),
    .out_valid (c_valid),
    .out_data  (c_data),
    .out_side  (c_side)
  );

  // Post stage 1: clamp and round the angle, split the gain multiply.
  always_comb begin
    if (c_data.z > HALF) begin
      z_clamp = HALF;
    end else if (c_data.z < NHALF) begin
      z_clamp = NHALF;
    end else begin
      z_clamp = c_data.z;
    end
    ang_sum = {z_clamp[ANG_W-1], z_clamp} + ANG_RND;
    ang_sh  = ang_sum >>> ANG_SHIFT;
    x_hi    = c_data.x[VEC_W-1:LO_W];
    x_lo    = {1'b0, c_data.x[LO_W-1:0]};
    y_hi    = c_data.y[VEC_W-1:LO_W];
    y_lo    = {1'b0, c_data.y[LO_W-1:0]};
  end

  // Post stage 2: recombine the partial products with the rounding offset.
  always_comb begin
    sx_next = {{(SUM_W-PH_W-LO_W){q1_pxh[PH_W-1]}}, q1_pxh, {LO_W{1'b0}}}
            + {{(SUM_W-PL_W){q1_pxl[PL_W-1]}}, q1_pxl} + OUT_RND;
    sy_next = {{(SUM_W-PH_W-LO_W){q1_pyh[PH_W-1]}}, q1_pyh, {LO_W{1'b0}}}
            + {{(SUM_W-PL_W){q1_pyl[PL_W-1]}}, q1_pyl} + OUT_RND;
  end

  // Post stage 3: scale down, saturate and select the result by action.
  always_comb begin
    sx_sh = q2_sx >>> OUT_SH;
    sy_sh = q2_sy >>> OUT_SH;
    sat_x = saturate(sx_sh[SCL_W-1:0]);
    sat_y = saturate(sy_sh[SCL_W-1:0]);
    res_next = '0;
    case (q2_side.action)
      ACT_LOAD: begin
        res_next.first_out  = q2_side.a;
        res_next.second_out = q2_side.b;
      end
      ACT_TO_RECT: begin
        res_next.first_out  = sat_x[DATA_W-1:0];
        res_next.second_out = sat_y[DATA_W-1:0];
        res_next.error_flag = sat_x[DATA_W] | sat_y[DATA_W];
      end
      ACT_TO_POLAR: begin
        if (!q2_side.zero_vec) begin
          res_next.first_out  = sat_x[DATA_W-1:0];
          res_next.second_out = q2_ang;
          res_next.error_flag = sat_x[DATA_W];
        end
      end
      default: begin
        res_next.error_flag = 1'b1;
      end
    endcase
  end

  // Back-end valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid  <= 1'b0;
      q2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      q1_valid  <= c_valid;
      q2_valid  <= q1_valid;
      res_valid <= q2_valid;
    end
  end

  // Back-end payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      q1_side    <= c_side;
      q1_ang     <= ang_sh[DATA_W-1:0];
      q1_pxh     <= x_hi * INV_GAIN;
      q1_pxl     <= x_lo * INV_GAIN;
      q1_pyh     <= y_hi * INV_GAIN;
      q1_pyl     <= y_lo * INV_GAIN;
      q2_side    <= q1_side;
      q2_ang     <= q1_ang;
      q2_sx      <= sx_next;
      q2_sy      <= sy_next;
      res_q      <= res_next;
      res_action <= q2_side.action;
    end
  end

  // Output skid entry: catches the last stage when the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid && !result.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_res <= res_q;
    end
  end

  // Output channel.
  assign out_res           = skid_valid ? skid_res : res_q;
  assign result.valid      = skid_valid | res_valid;
  assign result.first_out  = out_res.first_out;
  assign result.second_out = out_res.second_out;
  assign result.error_flag = out_res.error_flag;

  // The reduced integer angle always lies in 0..359.
  a_deg_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_deg < DEG_FULL))
    else $error("reduced angle out of range");

  // A rotation starts within the convergence range of plus or minus 90 degrees.
  a_rot_start: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s3_data.vec) |-> ((s3_data.z <= QUARTER) && (s3_data.z >= NQUARTER)))
    else $error("rotation angle outside convergence range");

  // A magnitude is never negative.
  a_mag_sign: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_action == ACT_TO_POLAR)) |-> !res_q.first_out[DATA_W-1])
    else $error("negative magnitude");

  // An invalid action yields zeros with the error flag.
  a_invalid: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_action == ACT_INVALID)) |->
      (res_q.error_flag && (res_q.first_out == '0) && (res_q.second_out == '0)))
    else $error("invalid action result malformed");

endmodule

/* rtl/prc_cordic.sv */
// ----------------------------------------------------------------------------
// prc_cordic: unrolled CORDIC pipeline
// One shift-add micro-rotation per register stage, in rotation or vectoring
// mode per transaction. Side information travels with each stage.
// ----------------------------------------------------------------------------
module prc_cordic import prc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    in_valid,
  input  cordic_t in_data,
  input  side_t   in_side,
  output logic    out_valid,
  output cordic_t out_data,
  output side_t   out_side
);

  logic    vld  [1:CORDIC_STAGES];
  cordic_t data [1:CORDIC_STAGES];
  side_t   side [1:CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ATAN_I = atan_deg(i);
    logic                    cur_vld;
    cordic_t                 cur;
    side_t                   cur_side;
    cordic_t                 nxt;
    logic                    ccw;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;

    if (i == 0) begin : g_first
      assign cur_vld  = in_valid;
      assign cur      = in_data;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_vld  = vld[i];
      assign cur      = data[i];
      assign cur_side = side[i];
    end

    // Micro-rotation: direction from the sign of y (vectoring) or z.
    always_comb begin
      dx  = $signed(cur.y) >>> i;
      dy  = $signed(cur.x) >>> i;
      ccw = cur.vec ? cur.y[VEC_W-1] : !cur.z[ANG_W-1];
      nxt = cur;
      if (ccw) begin
        nxt.x = cur.x - dx;
        nxt.y = cur.y + dy;
        nxt.z = cur.z - ATAN_I;
      end else begin
        nxt.x = cur.x + dx;
        nxt.y = cur.y - dy;
        nxt.z = cur.z + ATAN_I;
      end
    end

    // Stage valid bit.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (advance) begin
        vld[i+1] <= cur_vld;
      end
    end

    // Stage payload.
    always_ff @(posedge clk) begin
      if (advance) begin
        data[i+1] <= nxt;
        side[i+1] <= cur_side;
      end
    end
  end

  assign out_valid = vld[CORDIC_STAGES];
  assign out_data  = data[CORDIC_STAGES];
  assign out_side  = side[CORDIC_STAGES];

endmodule
